### sv/ltlm_pkg.sv
// Shared types and constants for the load throttle level monitor.
// Used by ltlm_div and load_throttle_level_monitor_core.
package ltlm_pkg;

  // Width of the sample, threshold and result fields.
  localparam int unsigned DataW = 10;

  // Default depth of the sample history ring.
  localparam int unsigned HistoryDepthDef = 64;

  // Register reset values.
  localparam logic [DataW-1:0] LowThreshRst  = 10'd500;
  localparam logic [DataW-1:0] HighThreshRst = 10'd700;
  localparam logic [DataW-1:0] MaxThreshRst  = 10'd900;

  // Configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgLowThresh  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHighThresh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxThresh  = 2'd2;

  // Throttle curve points in per-mille.
  localparam logic [DataW-1:0] LvlKnee = 10'd300;
  localparam logic [DataW-1:0] LvlFull = 10'd1000;
  localparam int unsigned GentleSpan = 300;
  localparam int unsigned SteepSpan  = 500;

  // Numerator of a level division: 500 * 1023 fits in 19 bits.
  localparam int unsigned LvlNumW = 19;

  // Sequencer states.
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StUpdate = 5'b00010,
    StDivAvg = 5'b00100,
    StDivLvl = 5'b01000,
    StResult = 5'b10000
  } ltlm_state_e;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/load_throttle_level_monitor_core.sv
// Load throttle level monitor: top level.
// Depends on ltlm_pkg, ltlm_ram and ltlm_div.
//
// Usage:
//   Load samples (tenths of a percent) enter on the in_valid_i/in_ready_o channel;
//   each accepted sample gives exactly one result transaction on
//   out_valid_o/out_ready_i carrying the moving average over the filled part of the
//   history ring, the peak sample since reset, the throttle level in per-mille and the
//   throttling flag. Thresholds are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   while the block is idle, which the user must ensure as the block does not enforce
//   it; index 0 is low, 1 is high, 2 is max, others are ignored.
// Sequence:
//   One sample at a time. A sample takes an update step, the shared serial
//   divider for the average, the divider again for the level when the
//   sample lies between low and max, and a last step to load the result
//   register. in_ready_o rises together with out_valid_o, so a new sample is
//   accepted only after the result of the previous one has been loaded.
// Reset:
//   History reads as zero until written (tracked by the fill count, no
//   clearing pass), thresholds return to 500/700/900, peak and counts clear.
// Stall:
//   A waiting result sits in the output register; the next sample is taken
//   and computed meanwhile, and holds in the last step until the register
//   is free.
module load_throttle_level_monitor_core import ltlm_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DataW-1:0]   usage_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DataW-1:0]   average_usage_o,
  output logic [DataW-1:0]   peak_usage_o,
  output logic [DataW-1:0]   throttle_level_o,
  output logic               throttling_active_o
);

  localparam int unsigned SlotW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SumW  = DataW + FillW;
  localparam int unsigned NumW  = (SumW > LvlNumW) ? SumW : LvlNumW;
  localparam int unsigned DenW  = (FillW > DataW) ? FillW : DataW;

  ltlm_state_e state_q, state_d;

  logic [DataW-1:0] low_q, high_q, max_q;
  logic [DataW-1:0] sample_q;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [SumW-1:0]  total_q, total_d;
  logic [DataW-1:0] peak_q, peak_d;

  logic [LvlNumW-1:0] lvl_num_q, lvl_num_d;
  logic [DataW-1:0]   lvl_den_q, lvl_den_d;
  logic [DataW-1:0]   lvl_base_q, lvl_base_d;
  logic               lvl_div_q, lvl_div_d;
  logic [DataW-1:0]   avg_q, avg_d;
  logic [DataW-1:0]   lvl_q, lvl_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_avg_q, out_peak_q, out_lvl_q;
  logic             out_flag_q;
  logic             out_load;

  logic [DataW-1:0] ram_rdata;
  logic             ram_we;
  logic [DataW-1:0] old_sample;
  logic             full;

  logic            div_start;
  logic [NumW-1:0] div_num;
  logic [DenW-1:0] div_den;
  logic [NumW-1:0] div_quo;
  div_stat_t       div_stat;

  logic in_acc;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (fill_q == FillW'(HISTORY_DEPTH));
  // An entry was written only once the ring has wrapped, else it still reads as zero.
  assign old_sample = full ? ram_rdata : '0;
  assign ram_we     = (state_q == StUpdate);
  assign out_load   = (state_q == StResult) && (!out_valid_q || out_ready_i);

  ltlm_ram #(
    .Width (DataW),
    .Depth (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  ltlm_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // Ring, sum and peak update, and the choice of throttle segment.
  always_comb begin
    slot_d     = slot_q;
    fill_d     = fill_q;
    total_d    = total_q;
    peak_d     = peak_q;
    lvl_num_d  = lvl_num_q;
    lvl_den_d  = lvl_den_q;
    lvl_base_d = lvl_base_q;
    lvl_div_d  = lvl_div_q;
    if (state_q == StUpdate) begin
      total_d = total_q - SumW'(old_sample) + SumW'(sample_q);
      slot_d  = (slot_q == SlotW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      fill_d  = full ? fill_q : fill_q + 1'b1;
      peak_d  = (sample_q > peak_q) ? sample_q : peak_q;
      priority if (sample_q < low_q) begin
        lvl_div_d  = 1'b0;
        lvl_base_d = '0;
        lvl_num_d  = '0;
        lvl_den_d  = '0;
      end else if (sample_q < high_q) begin
        lvl_div_d  = 1'b1;
        lvl_base_d = '0;
        lvl_num_d  = LvlNumW'(sample_q - low_q) * LvlNumW'(GentleSpan);
        lvl_den_d  = high_q - low_q;
      end else if (sample_q < max_q) begin
        lvl_div_d  = 1'b1;
        lvl_base_d = LvlKnee;
        lvl_num_d  = LvlNumW'(sample_q - high_q) * LvlNumW'(SteepSpan);
        lvl_den_d  = max_q - high_q;
      end else begin
        lvl_div_d  = 1'b0;
        lvl_base_d = LvlFull;
        lvl_num_d  = '0;
        lvl_den_d  = '0;
      end
    end
  end

  // Sequencer around the shared divider.
  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    div_num     = NumW'(lvl_num_q);
    div_den     = DenW'(lvl_den_q);
    avg_d       = avg_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        div_start = 1'b1;
        div_num   = NumW'(total_d);
        div_den   = DenW'(fill_d);
        state_d   = StDivAvg;
      end
      StDivAvg: begin
        if (div_stat.done) begin
          avg_d = div_quo[DataW-1:0];
          if (lvl_div_q) begin
            div_start = 1'b1;
            state_d   = StDivLvl;
          end else begin
            lvl_d   = lvl_base_q;
            state_d = StResult;
          end
        end
      end
      StDivLvl: begin
        if (div_stat.done) begin
          lvl_d   = lvl_base_q + div_quo[DataW-1:0];
          state_d = StResult;
        end
      end
      StResult: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      low_q       <= LowThreshRst;
      high_q      <= HighThreshRst;
      max_q       <= MaxThreshRst;
      slot_q      <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgLowThresh:  low_q  <= cfg_wdata_i;
          CfgHighThresh: high_q <= cfg_wdata_i;
          CfgMaxThresh:  max_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= usage_sample_i;
    end
    lvl_num_q  <= lvl_num_d;
    lvl_den_q  <= lvl_den_d;
    lvl_base_q <= lvl_base_d;
    lvl_div_q  <= lvl_div_d;
    avg_q      <= avg_d;
    lvl_q      <= lvl_d;
    if (out_load) begin
      out_avg_q  <= avg_q;
      out_peak_q <= peak_q;
      out_lvl_q  <= lvl_q;
      out_flag_q <= (lvl_q != '0);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign average_usage_o     = out_avg_q;
  assign peak_usage_o        = out_peak_q;
  assign throttle_level_o    = out_lvl_q;
  assign throttling_active_o = out_flag_q;

  // The fill count saturates at the ring depth.
  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(HISTORY_DEPTH))
    else $error("fill count above history depth");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == StDivAvg || state_q == StDivLvl))
    else $error("divider finished outside a divide step");

  // A division is only started once the previous one has finished.
  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // A result flag always agrees with its level, and the level never exceeds full.
  a_flag_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (throttling_active_o == (throttle_level_o != '0))
                    && (throttle_level_o <= LvlFull))
    else $error("throttle flag or level inconsistent");

  // A new result is never loaded over one that has not been taken.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(throttle_level_o))
    else $error("pending result overwritten");

endmodule

### sv/ltlm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ltlm_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/ltlm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ltlm_pkg for the status struct.
module ltlm_div import ltlm_pkg::*; #(
  parameter int unsigned NumW = 19,
  parameter int unsigned DenW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o,
  output div_stat_t       stat_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   shifted;
  logic [DenW+1:0] diff;
  logic            ge;

  assign shifted = {rem_q, quo_q[NumW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = ~diff[DenW+1];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d = CntW'(NumW);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
      quo_d  = {quo_q[NumW-2:0], ge};
      rem_d  = ge ? diff[DenW-1:0] : shifted[DenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule
